// File: src/b85_pkg.sv
// Shared constants, register codes and character mapping for the base-85 group encoder.
package b85_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ALPHABET_SELECT = 2'd0,
    CFG_COMPRESS_ENABLE = 2'd1,
    CFG_COMPRESS_BYTE   = 2'd2,
    CFG_COMPRESS_CHAR   = 2'd3
  } cfg_index_t;

  localparam logic       ALPHABET_RESET = 1'b0;
  localparam logic       COMPRESS_ENABLE_RESET = 1'b1;
  localparam logic [7:0] COMPRESS_BYTE_RESET = 8'd0;
  localparam logic [7:0] COMPRESS_CHAR_RESET = 8'd122;

  localparam int RADIX = 85;
  localparam int DIGITS = 5;

  // Exact reciprocals for 32-bit unsigned division by powers of the radix. With
  // l = ceil(log2(d)) and m = floor(2^(32+l) / d) + 1, floor(x * m / 2^(32+l)) is the
  // true quotient for every 32-bit x.
  localparam int SHIFT_1 = 32 + 7;
  localparam int SHIFT_2 = 32 + 13;
  localparam int SHIFT_3 = 32 + 20;
  localparam int SHIFT_4 = 32 + 26;
  localparam logic [32:0] RECIP_1 = 33'(((64'd1 << SHIFT_1) / 64'd85) + 64'd1);
  localparam logic [32:0] RECIP_2 = 33'(((64'd1 << SHIFT_2) / 64'd7225) + 64'd1);
  localparam logic [32:0] RECIP_3 = 33'(((64'd1 << SHIFT_3) / 64'd614125) + 64'd1);
  localparam logic [32:0] RECIP_4 = 33'(((64'd1 << SHIFT_4) / 64'd52200625) + 64'd1);

  localparam logic [7:0] ASCII85_BASE = 8'd33;

  localparam logic [8*85-1:0] Z85_CHARS =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

  // Maps one radix-85 digit to its character in the chosen alphabet.
  function automatic logic [7:0] map_digit(input logic [6:0] digit, input logic z85);
    logic [6:0] d;
    d = (digit > 7'(RADIX - 1)) ? 7'(RADIX - 1) : digit;
    if (z85) begin
      return Z85_CHARS[8 * (RADIX - 1 - int'(d)) +: 8];
    end
    return ASCII85_BASE + {1'b0, d};
  endfunction

endpackage

// File: src/b85_if.sv
// Handshake channels of the base-85 group encoder: input group, result and register write.
interface b85_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] group_word;
  logic [2:0]  byte_count;

  modport source (output valid, output group_word, output byte_count, input ready);
  modport sink (input valid, input group_word, input byte_count, output ready);
endinterface

interface b85_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_0;
  logic [7:0] char_1;
  logic [7:0] char_2;
  logic [7:0] char_3;
  logic [7:0] char_4;
  logic [2:0] char_count;

  modport source (output valid, output char_0, output char_1, output char_2,
                  output char_3, output char_4, output char_count, input ready);
  modport sink (input valid, input char_0, input char_1, input char_2,
                input char_3, input char_4, input char_count, output ready);
endinterface

interface b85_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [7:0] write_data;

  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

// File: src/base85_group_encoder_top.sv
// Base-85 group encoder: one group of up to four bytes in, up to five characters out.
//
// The item channel carries a 32-bit word, first byte in bits 31:24, and a byte count.
// Each transfer on it yields exactly one transfer on the result channel, holding the
// characters in order, unused positions zero, and the number of valid characters.
// A count of zero is taken as one and a count above four as four.
//
// The conversion is a single registered pass: the five radix-85 digits come from four
// parallel reciprocal multiplications on the padded word, each followed by a small
// constant multiply and subtract, and the alphabet lookup feeds the result register.
// The result is offered in the cycle after an item transfer, and one item
// is taken in every cycle while the receiver keeps up.
//
// When the receiver stalls, the held result stays put and item ready drops in the same
// cycle; it rises again as soon as the result is taken, so no cycle is lost.
// Register writes are always taken and should only be made while the block is idle.
//
// Reset clears the result valid flag and returns the registers to Ascii85, compression
// on, compression byte zero and compression character 'z'.
module base85_group_encoder_top (
  input  logic          clk,
  input  logic          rst,
  b85_item_if.sink      item,
  b85_result_if.source  result,
  b85_cfg_if.sink       cfg
);

  // Configuration registers.
  logic       alphabet_select;
  logic       compress_enable;
  logic [7:0] compress_byte;
  logic [7:0] compress_char;

  // Result register.
  logic       result_valid;
  logic [7:0] chars [b85_pkg::DIGITS];
  logic [2:0] count;

  // Conversion datapath.
  logic        accept;
  logic [2:0]  n_eff;
  logic [31:0] word_pad;
  logic        compress_hit;
  logic [31:0] q1, q2, q3, q4;
  logic [6:0]  digits [b85_pkg::DIGITS];
  logic [7:0]  chars_next [b85_pkg::DIGITS];
  logic [2:0]  count_next;

  // Quotient of a 32-bit value by a constant, from its exact reciprocal.
  function automatic logic [31:0] div_recip(input logic [31:0] x, input logic [32:0] recip,
                                            input int shift);
    logic [64:0] prod;
    prod = {33'd0, x} * {32'd0, recip};
    return 32'(prod >> shift);
  endfunction

  // Register writes are accepted in every cycle.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_select <= b85_pkg::ALPHABET_RESET;
      compress_enable <= b85_pkg::COMPRESS_ENABLE_RESET;
      compress_byte   <= b85_pkg::COMPRESS_BYTE_RESET;
      compress_char   <= b85_pkg::COMPRESS_CHAR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (b85_pkg::cfg_index_t'(cfg.reg_index))
        b85_pkg::CFG_ALPHABET_SELECT: alphabet_select <= cfg.write_data[0];
        b85_pkg::CFG_COMPRESS_ENABLE: compress_enable <= cfg.write_data[0];
        b85_pkg::CFG_COMPRESS_BYTE:   compress_byte   <= cfg.write_data;
        b85_pkg::CFG_COMPRESS_CHAR:   compress_char   <= cfg.write_data;
        default: ;
      endcase
    end
  end

  // A new item may enter whenever the result register is empty or being emptied.
  assign item.ready = !rst && (!result_valid || result.ready);
  assign accept     = item.valid && item.ready;

  // Effective byte count, with zero read as one and anything above four as four.
  always_comb begin
    if (item.byte_count == 3'd0) begin
      n_eff = 3'd1;
    end else if (item.byte_count > 3'd4) begin
      n_eff = 3'd4;
    end else begin
      n_eff = item.byte_count;
    end
  end

  // Bytes beyond the count are padded with zeros.
  always_comb begin
    case (n_eff)
      3'd1:    word_pad = item.group_word & 32'hFF00_0000;
      3'd2:    word_pad = item.group_word & 32'hFFFF_0000;
      3'd3:    word_pad = item.group_word & 32'hFFFF_FF00;
      default: word_pad = item.group_word;
    endcase
  end

  // Only a full group of four copies of the compression byte is compressed.
  assign compress_hit = (n_eff == 3'd4) && compress_enable &&
                        (item.group_word == {4{compress_byte}});

  // Quotients by 85, 85^2, 85^3 and 85^4, all computed side by side.
  assign q1 = div_recip(word_pad, b85_pkg::RECIP_1, b85_pkg::SHIFT_1);
  assign q2 = div_recip(word_pad, b85_pkg::RECIP_2, b85_pkg::SHIFT_2);
  assign q3 = div_recip(word_pad, b85_pkg::RECIP_3, b85_pkg::SHIFT_3);
  assign q4 = div_recip(word_pad, b85_pkg::RECIP_4, b85_pkg::SHIFT_4);

  // Each digit is the difference between one quotient and 85 times the next one.
  always_comb begin
    logic [31:0] rem4, rem3, rem2, rem1;
    rem4 = word_pad - (q1 * 32'(b85_pkg::RADIX));
    rem3 = q1 - (q2 * 32'(b85_pkg::RADIX));
    rem2 = q2 - (q3 * 32'(b85_pkg::RADIX));
    rem1 = q3 - (q4 * 32'(b85_pkg::RADIX));
    digits[0] = q4[6:0];
    digits[1] = rem1[6:0];
    digits[2] = rem2[6:0];
    digits[3] = rem3[6:0];
    digits[4] = rem4[6:0];
  end

  // Character selection; positions past the count are zero.
  always_comb begin
    for (int i = 0; i < b85_pkg::DIGITS; i++) begin
      if (compress_hit) begin
        chars_next[i] = (i == 0) ? compress_char : 8'd0;
      end else if (3'(i) <= n_eff) begin
        chars_next[i] = b85_pkg::map_digit(digits[i], alphabet_select);
      end else begin
        chars_next[i] = 8'd0;
      end
    end
    count_next = compress_hit ? 3'd1 : (n_eff + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chars <= chars_next;
      count <= count_next;
    end
  end

  assign result.valid      = result_valid;
  assign result.char_0     = chars[0];
  assign result.char_1     = chars[1];
  assign result.char_2     = chars[2];
  assign result.char_3     = chars[3];
  assign result.char_4     = chars[4];
  assign result.char_count = count;

  // Every accepted item is offered as a result in the following cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted item did not produce a result");

  // A stalled result must hold off the next item so that it is not overwritten.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.ready) |-> !item.ready)
    else $error("item ready while a stalled result is held");

  // The character count of a held result lies between one and five.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (count != 3'd0 && count <= 3'd5))
    else $error("character count out of range");

  // The fifth character is zero unless the group was a full uncompressed one.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && count < 3'd5) |-> (chars[4] == 8'd0))
    else $error("unused character position is not zero");

  // A compressed group yields the compression character alone.
  a_compress_single: assert property (@(posedge clk) disable iff (rst)
    (accept && compress_hit) |=> (count == 3'd1 && chars[0] == $past(compress_char)))
    else $error("compressed group did not give a single compression character");

endmodule
